/* rtl/smm_pkg.sv */
// Shared types and constants of the square matrix multiplier.
// No dependencies; imported by every other file of the block except smm_ram.
package smm_pkg;

  // Built defaults of the top level parameters
  localparam int MAX_DIM_DEF    = 8;
  localparam int ELEM_WIDTH_DEF = 16;

  // Fixed field widths
  localparam int OPCODE_W  = 2;
  localparam int IDX_W     = 3;
  localparam int IN_ELEM_W = 16;
  localparam int SUM_W     = 36;
  localparam int SIZE_W    = 4;

  // Opcodes of the input item
  localparam logic [OPCODE_W-1:0] OP_WRITE_A = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE_B = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_COMPUTE = 2'd2;

  // Configuration register map
  localparam int                  CFG_ADDR_W       = 2;
  localparam int                  CFG_DATA_W       = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MATRIX_SIZE = 2'd0;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  // Control that travels with each operand pair down the MAC pipeline
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic             last_elem;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } smm_tag_t;

endpackage

/* rtl/smm_if.sv */
// Valid/ready channel interfaces for load/compute items and product elements.
// Depends on smm_pkg.
interface smm_in_if import smm_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic [OPCODE_W-1:0]         opcode;
  logic [IDX_W-1:0]            row_index;
  logic [IDX_W-1:0]            col_index;
  logic signed [IN_ELEM_W-1:0] element_value;

  modport source (output valid, opcode, row_index, col_index, element_value, input ready);
  modport sink   (input valid, opcode, row_index, col_index, element_value, output ready);
endinterface

interface smm_out_if import smm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] product_value;
  logic                    last_element;

  modport source (output valid, out_row, out_col, product_value, last_element, input ready);
  modport sink   (input valid, out_row, out_col, product_value, last_element, output ready);
endinterface

/* rtl/smm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/smm_cfg.sv */
// APB-style configuration register: matrix size, clamped to the usable range.
// Depends on smm_pkg.
module smm_cfg import smm_pkg::*; #(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [SIZE_W-1:0]     n_act
);

  logic [SIZE_W-1:0] size_r;
  logic              size_sel;

  assign size_sel = (paddr == ADDR_MATRIX_SIZE);
  assign pready   = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(MAX_DIM);
    end else if (psel && penable && pwrite && size_sel) begin
      size_r <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (size_sel) begin
      prdata = CFG_DATA_W'(size_r);
    end
  end

  // zero acts as one, anything beyond the built size as the built size
  always_comb begin
    if (size_r == '0) begin
      n_act = SIZE_W'(1);
    end else if (size_r > SIZE_W'(MAX_DIM)) begin
      n_act = SIZE_W'(MAX_DIM);
    end else begin
      n_act = size_r;
    end
  end

endmodule

/* rtl/smm_ctrl.sv */
// Input handling, the two element stores with their valid bits, and the
// i/j/k sequencer that reads one A and one B operand per cycle unless stalled.
// Depends on smm_pkg, smm_if and smm_ram.
module smm_ctrl import smm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  smm_in_if.sink                       in_ch,
  input  logic [SIZE_W-1:0]            n_act,
  input  logic                         stall,
  input  logic                         mac_busy,
  output smm_tag_t                     tag,
  output logic signed [ELEM_WIDTH-1:0] a_data,
  output logic signed [ELEM_WIDTH-1:0] b_data
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, nm1_r, nm1_nxt;
  logic             issue;
  smm_tag_t         tag1_r, tag1_nxt;
  logic             va1_r, vb1_r;
  logic [DEPTH-1:0] vld_a_r, vld_b_r;

  logic                  in_fire, in_range, load_a, load_b, start;
  logic [ADDR_W-1:0]     wr_addr, a_addr, b_addr;
  logic [ELEM_WIDTH-1:0] wr_data, a_rdata, b_rdata;

  assign in_ch.ready = (state_r == SEQ_IDLE) && !tag1_r.valid && !mac_busy;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_range    = (int'(in_ch.row_index) < MAX_DIM) && (int'(in_ch.col_index) < MAX_DIM);
  assign wr_addr     = ADDR_W'(int'(in_ch.row_index) * MAX_DIM + int'(in_ch.col_index));
  assign wr_data     = ELEM_WIDTH'(in_ch.element_value);

  always_comb begin
    load_a = 1'b0;
    load_b = 1'b0;
    start  = 1'b0;
    unique case (in_ch.opcode)
      OP_WRITE_A: load_a = in_fire && in_range;
      OP_WRITE_B: load_b = in_fire && in_range;
      OP_COMPUTE: start  = in_fire;
      default:    ;
    endcase
  end

  assign a_addr = ADDR_W'(int'(i_r) * MAX_DIM + int'(k_r));
  assign b_addr = ADDR_W'(int'(k_r) * MAX_DIM + int'(j_r));

  smm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (load_a),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (!stall),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  smm_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (load_b),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (!stall),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= '0;
      vld_b_r <= '0;
    end else begin
      if (load_a) begin
        vld_a_r[wr_addr] <= 1'b1;
      end
      if (load_b) begin
        vld_b_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      nm1_r   <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      nm1_r   <= nm1_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    nm1_nxt   = nm1_r;
    issue     = 1'b0;
    unique case (state_r)
      SEQ_IDLE: begin
        if (start) begin
          state_nxt = SEQ_RUN;
          i_nxt     = '0;
          j_nxt     = '0;
          k_nxt     = '0;
          nm1_nxt   = IDX_W'(n_act - SIZE_W'(1));
        end
      end
      SEQ_RUN: begin
        if (!stall) begin
          issue = 1'b1;
          if (k_r == nm1_r) begin
            k_nxt = '0;
            if (j_r == nm1_r) begin
              j_nxt = '0;
              if (i_r == nm1_r) begin
                state_nxt = SEQ_IDLE;
              end else begin
                i_nxt = i_r + IDX_W'(1);
              end
            end else begin
              j_nxt = j_r + IDX_W'(1);
            end
          end else begin
            k_nxt = k_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = SEQ_IDLE;
    endcase
  end

  // tag stage lines up with the registered RAM read data
  always_comb begin
    tag1_nxt.valid     = issue;
    tag1_nxt.first     = (k_r == '0);
    tag1_nxt.last      = (k_r == nm1_r);
    tag1_nxt.last_elem = (i_r == nm1_r) && (j_r == nm1_r) && (k_r == nm1_r);
    tag1_nxt.row       = i_r;
    tag1_nxt.col       = j_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      va1_r  <= 1'b0;
      vb1_r  <= 1'b0;
    end else if (!stall) begin
      tag1_r <= tag1_nxt;
      va1_r  <= vld_a_r[a_addr];
      vb1_r  <= vld_b_r[b_addr];
    end
  end

  assign tag    = tag1_r;
  assign a_data = va1_r ? a_rdata : '0;
  assign b_data = vb1_r ? b_rdata : '0;

endmodule

/* rtl/smm_mac.sv */
// Multiply-accumulate pipeline with saturation and the result output register.
// Depends on smm_pkg and smm_if.
module smm_mac import smm_pkg::*; #(
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  smm_tag_t                     tag,
  input  logic signed [ELEM_WIDTH-1:0] a_data,
  input  logic signed [ELEM_WIDTH-1:0] b_data,
  output logic                         stall,
  output logic                         mac_busy,
  smm_out_if.source                    out_ch
);

  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int ACC_W  = (PROD_W + 3 > SUM_W) ? PROD_W + 3 : SUM_W;
  localparam int HI_W   = ACC_W - SUM_W + 1;

  smm_tag_t                tag2_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_sum;
  logic [HI_W-1:0]          hi_bits;
  logic [SUM_W-1:0]         sat_val;
  logic                     done;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_val_r;
  logic                    out_last_r;

  assign stall    = out_valid_r && !out_ch.ready;
  assign mac_busy = tag2_r.valid;
  assign prod_nxt = a_data * b_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (!stall) begin
      tag2_r <= tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      prod_r <= prod_nxt;
    end
  end

  always_comb begin
    if (tag2_r.first) begin
      acc_sum = ACC_W'(prod_r);
    end else begin
      acc_sum = acc_r + ACC_W'(prod_r);
    end
  end

  // clamp to the signed 36-bit range when the upper bits are not all sign
  assign hi_bits = acc_sum[ACC_W-1 -: HI_W];
  always_comb begin
    if ((&hi_bits) || !(|hi_bits)) begin
      sat_val = acc_sum[SUM_W-1:0];
    end else if (acc_sum[ACC_W-1]) begin
      sat_val = {1'b1, {(SUM_W-1){1'b0}}};
    end else begin
      sat_val = {1'b0, {(SUM_W-1){1'b1}}};
    end
  end

  assign done = !stall && tag2_r.valid && tag2_r.last;

  always_ff @(posedge clk) begin
    if (!stall && tag2_r.valid) begin
      acc_r <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_row_r  <= tag2_r.row;
      out_col_r  <= tag2_r.col;
      out_val_r  <= sat_val;
      out_last_r <= tag2_r.last_elem;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.out_row       = out_row_r;
  assign out_ch.out_col       = out_col_r;
  assign out_ch.product_value = out_val_r;
  assign out_ch.last_element  = out_last_r;

endmodule

/* rtl/square_matrix_multiply.sv */
// Square matrix multiplier: two element stores, an i/j/k sequencer and one MAC.
// Depends on smm_pkg, smm_if, smm_ram, smm_cfg, smm_ctrl and smm_mac.
//
// A load item (write A or write B) writes one element of the left or right
// store; a write outside the built size, or opcode 3, is taken and dropped. A
// compute item reads one A and one B element per cycle, unless the output
// stalls, from the two stores and feeds the single multiply-accumulate unit
// (n = matrix_size, clamped to 1..MAX_DIM), emitting the n*n product elements
// in row-major order with last_element set on the final one. The next item is
// taken once the final element has reached the output register; a stalled
// output freezes the whole pipeline. Both stores read as zero after reset
// through per-entry valid bits, so no clearing pass is needed.
module square_matrix_multiply import smm_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  smm_in_if.sink                in_ch,
  smm_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [SIZE_W-1:0]            n_act;
  logic                         stall;
  logic                         mac_busy;
  smm_tag_t                     tag;
  logic signed [ELEM_WIDTH-1:0] a_data;
  logic signed [ELEM_WIDTH-1:0] b_data;

  smm_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .n_act   (n_act)
  );

  smm_ctrl #(.MAX_DIM(MAX_DIM), .ELEM_WIDTH(ELEM_WIDTH)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .n_act    (n_act),
    .stall    (stall),
    .mac_busy (mac_busy),
    .tag      (tag),
    .a_data   (a_data),
    .b_data   (b_data)
  );

  smm_mac #(.ELEM_WIDTH(ELEM_WIDTH)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag      (tag),
    .a_data   (a_data),
    .b_data   (b_data),
    .stall    (stall),
    .mac_busy (mac_busy),
    .out_ch   (out_ch)
  );

endmodule

/* bench/tb_square_matrix_multiply.sv */
// Self-checking bench for square_matrix_multiply: loads A and B, computes, checks every C element.
// Depends on smm_pkg, smm_if and the RTL of the block; the predictor is a fixed-point triple loop.
// Covers directed corner cases, random load/compute sequences, output back-pressure and back-to-back transfers.
module tb_square_matrix_multiply import smm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = MAX_DIM_DEF;
  localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
  localparam int SETTLE = 8;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    last;
  } product_t;

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  smm_in_if  in_ch ();
  smm_out_if out_ch ();

  // Predictor state
  logic signed [IN_ELEM_W-1:0] a_store [DIM*DIM];
  logic signed [IN_ELEM_W-1:0] b_store [DIM*DIM];
  logic [SIZE_W-1:0]           size_reg;
  product_t                    pending_products [$];

  int errors;
  bit bursty;
  bit hold_req;

  square_matrix_multiply dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[square_matrix_multiply] ERROR");
    $finish;
  end

  function automatic void flag_field(string field, logic signed [63:0] want,
                                     logic signed [63:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endfunction

  function automatic int active_dim(logic [SIZE_W-1:0] sz);
    if (sz == 0) return 1;
    if (sz > DIM) return DIM;
    return sz;
  endfunction

  function automatic logic signed [IN_ELEM_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '0;
      3: return '1;
      default: return IN_ELEM_W'($urandom);
    endcase
  endfunction

  function automatic logic [OPCODE_W-1:0] load_opcode();
    return $urandom_range(0, 1) ? OP_WRITE_B : OP_WRITE_A;
  endfunction

  // Mirror of the block: store updates on loads, full C = A * B on compute
  function automatic void predict_item(logic [OPCODE_W-1:0] op, logic [IDX_W-1:0] row,
                                       logic [IDX_W-1:0] col,
                                       logic signed [IN_ELEM_W-1:0] value);
    product_t p;
    int       n;
    int       i;
    int       j;
    int       k;
    longint   acc;
    longint   hi;
    hi = (longint'(1) <<< (SUM_W - 1)) - 1;
    case (op)
      OP_WRITE_A: if (row < DIM && col < DIM) a_store[row*DIM + col] = value;
      OP_WRITE_B: if (row < DIM && col < DIM) b_store[row*DIM + col] = value;
      OP_COMPUTE: begin
        n = active_dim(size_reg);
        for (i = 0; i < n; i++) begin
          for (j = 0; j < n; j++) begin
            acc = 0;
            for (k = 0; k < n; k++)
              acc += longint'(a_store[i*DIM + k]) * longint'(b_store[k*DIM + j]);
            if (acc > hi) acc = hi;
            if (acc < -hi - 1) acc = -hi - 1;
            p.row   = i[IDX_W-1:0];
            p.col   = j[IDX_W-1:0];
            p.value = acc[SUM_W-1:0];
            p.last  = (i == n - 1) && (j == n - 1);
            pending_products.push_back(p);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // One input transfer, with an optional random gap in front of it
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col,
                           input logic signed [IN_ELEM_W-1:0] value);
    if (bursty && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.opcode        <= op;
    in_ch.row_index     <= row;
    in_ch.col_index     <= col;
    in_ch.element_value <= value;
    do @(posedge clk); while (!in_ch.ready);
    predict_item(op, row, col, value);
  endtask

  // Always advances past a clock edge so valid is never dropped and raised in one step
  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_products.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Optional write transfer, then a read transfer checked against the predicted register
  task automatic cfg_access(input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data, input bit do_write);
    psel  <= 1'b1;
    paddr <= addr;
    if (do_write) begin
      pwrite  <= 1'b1;
      pwdata  <= data;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      if (addr == ADDR_MATRIX_SIZE) size_reg = data[SIZE_W-1:0];
    end
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    flag_field("matrix_size readback", size_reg, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic test_reset_state();
    cfg_access(ADDR_MATRIX_SIZE, '0, 1'b0);
    // nothing loaded yet: full 8x8 product of zeros
    send_item(OP_COMPUTE, 0, 0, '0);
  endtask

  task automatic test_directed_cases();
    wait_drained(SETTLE);
    cfg_access(ADDR_MATRIX_SIZE, 2, 1'b1);
    send_item(OP_WRITE_A, 0, 0, 16'sh8000);
    send_item(OP_WRITE_A, 0, 1, 16'sh8000);
    send_item(OP_WRITE_A, 1, 0, 16'sh7fff);
    send_item(OP_WRITE_A, 1, 1, 16'sh8000);
    send_item(OP_WRITE_B, 0, 0, 16'sh8000);
    send_item(OP_WRITE_B, 1, 0, 16'sh8000);
    send_item(OP_WRITE_B, 0, 1, 16'sh7fff);
    send_item(OP_WRITE_B, 1, 1, 16'sh7fff);
    send_item(OP_COMPUTE, 7, 7, '1);
    send_item(OP_RESERVED, 7, 7, 16'sh7fff);
    // outside the active corner: kept, and picked up once the size grows
    send_item(OP_WRITE_A, 7, 7, 16'sh7fff);
    send_item(OP_WRITE_B, 7, 7, 16'sh8000);
    send_item(OP_RESERVED, 0, 0, 16'sh0000);
    wait_drained(SETTLE);
    cfg_access(ADDR_MATRIX_SIZE, 0, 1'b1);
    send_item(OP_COMPUTE, 0, 0, '0);
    wait_drained(SETTLE);
    cfg_access(ADDR_MATRIX_SIZE, 15, 1'b1);
    send_item(OP_COMPUTE, 5, 2, 16'sh1234);
  endtask

  task automatic test_random_sequences();
    int sizes [12] = '{1, 3, 2, 8, 0, 5, 15, 4, 7, 6, 2, 3};
    int n;
    int quota;
    int sent;
    int loads;
    foreach (sizes[p]) begin
      wait_drained(SETTLE);
      cfg_access(ADDR_MATRIX_SIZE, sizes[p], 1'b1);
      n = active_dim(size_reg);
      quota = (n >= 7) ? 12 : 26;
      sent = 0;
      while (sent < quota) begin
        if ($urandom_range(0, 3) != 0) begin
          loads = $urandom_range(1, 2 * n);
          repeat (loads)
            send_item(load_opcode(), IDX_W'($urandom_range(0, n - 1)),
                      IDX_W'($urandom_range(0, n - 1)), pick_value());
          send_item(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                    pick_value());
          sent += loads + 1;
        end else begin
          // noise: any opcode, any index
          send_item(OPCODE_W'($urandom), IDX_W'($urandom_range(0, 7)),
                    IDX_W'($urandom_range(0, 7)), pick_value());
          sent++;
        end
      end
    end
  endtask

  task automatic test_output_stall();
    wait_drained(SETTLE);
    cfg_access(ADDR_MATRIX_SIZE, 3, 1'b1);
    // sink holds off while items keep coming, so the block backs up to its input
    hold_req = 1'b1;
    repeat (4) begin
      repeat (3)
        send_item(load_opcode(), IDX_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 2)),
                  pick_value());
      send_item(OP_COMPUTE, 0, 0, '0);
    end
    wait_drained(0);
    repeat (3)
      send_item(load_opcode(), IDX_W'($urandom_range(0, 2)), IDX_W'($urandom_range(0, 2)),
                pick_value());
    send_item(OP_COMPUTE, 0, 0, '0);
  endtask

  task automatic test_back_to_back();
    wait_drained(SETTLE);
    cfg_access(ADDR_MATRIX_SIZE, 4, 1'b1);
    bursty = 1'b0;
    repeat (5) begin
      repeat ($urandom_range(4, 10))
        send_item(load_opcode(), IDX_W'($urandom_range(0, 3)), IDX_W'($urandom_range(0, 3)),
                  pick_value());
      send_item(OP_COMPUTE, IDX_W'($urandom_range(0, 7)), IDX_W'($urandom_range(0, 7)),
                pick_value());
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin : product_sink
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : product_checker
    product_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (pending_products.size() == 0) begin
          errors++;
          $display("%0t: unexpected product transfer (%0d,%0d) = %0d", $time,
                   out_ch.out_row, out_ch.out_col, out_ch.product_value);
        end else begin
          want = pending_products.pop_front();
          flag_field("out_row", want.row, out_ch.out_row);
          flag_field("out_col", want.col, out_ch.out_col);
          flag_field("product_value", want.value, out_ch.product_value);
          flag_field("last_element", want.last, out_ch.last_element);
        end
      end
    end
  end

  initial begin
    rst_n               = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_ch.valid         = 1'b0;
    in_ch.opcode        = OP_WRITE_A;
    in_ch.row_index     = '0;
    in_ch.col_index     = '0;
    in_ch.element_value = '0;
    errors              = 0;
    bursty              = 1'b1;
    hold_req            = 1'b0;
    size_reg            = DIM;
    foreach (a_store[i]) begin
      a_store[i] = '0;
      b_store[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_directed_cases();
    test_random_sequences();
    test_output_stall();
    test_back_to_back();

    wait_drained(SETTLE * 2);
    if (errors == 0 && pending_products.size() == 0) begin
      $display("[square_matrix_multiply] OK");
    end else begin
      $display("[square_matrix_multiply] ERROR");
    end
    $finish;
  end

endmodule
